// ----- rtl/wmm_pkg.sv -----
// Shared types and constants for the windowed min/max/mean block.
package wmm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int FILL_W   = 7;
  localparam int SUM_W    = SAMPLE_W + FILL_W;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic       REG_WINDOW_LEN   = 1'b0;
  localparam logic [FILL_W-1:0] WINDOW_LEN_RST = 7'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_META,
    ST_WALK,
    ST_DIV,
    ST_DONE
  } wmm_state_t;

  typedef struct packed {
    logic in_ready;
    logic meta_we;
    logic hist_we;
    logic rd_issue;
    logic div_start;
    logic out_load;
  } wmm_ctrl_t;

endpackage

// ----- rtl/wmm_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
module wmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/wmm_div.sv -----
// Bit-serial signed-by-unsigned divider, truncating toward zero.
module wmm_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [wmm_pkg::SUM_W-1:0]    dividend,
  input  logic [wmm_pkg::FILL_W-1:0]          divisor,
  output logic                         done,
  output logic [wmm_pkg::SAMPLE_W-1:0] quotient
);

  import wmm_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  mag_r, mag_nxt;
  logic [FILL_W-1:0] rem_r, rem_nxt;
  logic [FILL_W-1:0] dvs_r;
  logic              neg_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [FILL_W:0]   rem_sh;
  logic [FILL_W+1:0] diff;
  logic [SUM_W-1:0]  q_signed;

  always_comb begin
    rem_sh   = {rem_r, mag_r[SUM_W-1]};
    diff     = {1'b0, rem_sh} - {2'b00, dvs_r};
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      mag_nxt  = dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[FILL_W+1]) begin
        rem_nxt = diff[FILL_W-1:0];
        mag_nxt = {mag_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[FILL_W-1:0];
        mag_nxt = {mag_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
      neg_r <= dividend[SUM_W-1];
    end
  end

  assign q_signed = neg_r ? SUM_W'(-mag_r) : mag_r;
  assign quotient = q_signed[SAMPLE_W-1:0];
  assign done     = done_r;

endmodule

// ----- rtl/windowed_min_max_mean_top.sv -----
// Top level: per-channel sliding-window max, min, mean and fill count.
//
// Usage:
//   in_*  : one beat per sample (channel, signed sample), valid/ready.
//   out_* : one beat per input beat with max, min, mean and fill count.
//   cfg_* : APB-style register port; window_len at byte address 0.
// Each beat reads the channel's ring state from a small RAM, writes the
// sample into the history RAM, then reads back fill_count entries one per
// cycle for max/min/sum, then divides the sum bit-serially.
// One beat is in work at a time: a new beat is accepted only once the
// core has handed the last result to the output register. The history
// RAM read port and the serial divider set the time each beat takes.
// The output register frees the core: the next input beat is accepted
// while a result waits; a finished result waits in the core until the
// output register empties when the receiver stalls.
// Reset (rst_n, synchronous) empties every window through per-channel
// valid bits; no clearing pass is needed. window_len resets to 64.
module windowed_min_max_mean_top #(
  parameter int NUM_CHANNELS = 16,
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [3:0]                       in_channel,
  input  logic signed [wmm_pkg::SAMPLE_W-1:0] in_sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [wmm_pkg::SAMPLE_W-1:0] out_max_value,
  output logic signed [wmm_pkg::SAMPLE_W-1:0] out_min_value,
  output logic signed [wmm_pkg::SAMPLE_W-1:0] out_mean_value,
  output logic [wmm_pkg::FILL_W-1:0]       out_fill_count,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [wmm_pkg::ADDR_W-1:0]       cfg_paddr,
  input  logic [wmm_pkg::DATA_W-1:0]       cfg_pwdata,
  output logic [wmm_pkg::DATA_W-1:0]       cfg_prdata,
  output logic                             cfg_pready
);

  import wmm_pkg::*;

  localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PW        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int HA_W      = CH_W + PW;
  localparam int META_W    = PW + FILL_W;
  localparam int DEPTH_CAP = (WINDOW_DEPTH > 127) ? 127 : WINDOW_DEPTH;
  localparam logic [PW-1:0]     LAST_POS = PW'(WINDOW_DEPTH - 1);
  localparam logic [FILL_W-1:0] CAP_LEN  = FILL_W'(DEPTH_CAP);

  // Config register
  logic [FILL_W-1:0] window_len_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_WINDOW_LEN);
  assign cfg_prdata = (cfg_paddr[2] == REG_WINDOW_LEN) ?
                      {{(DATA_W - FILL_W){1'b0}}, window_len_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= WINDOW_LEN_RST;
    end else if (cfg_wr) begin
      window_len_r <= cfg_pwdata[FILL_W-1:0];
    end
  end

  // Channel wrap table
  logic [CH_W-1:0] ch_mod_tab [16];
  for (genvar g = 0; g < 16; g++) begin : g_chmod
    assign ch_mod_tab[g] = CH_W'(g % NUM_CHANNELS);
  end

  // State and control
  wmm_state_t state_r, state_nxt;
  wmm_ctrl_t  ctrl;

  logic [CH_W-1:0]            ch_r;
  logic [SAMPLE_W-1:0]        sample_r;
  logic [FILL_W-1:0]          len_r;
  logic [FILL_W-1:0]          len_eff;
  logic [FILL_W-1:0]          fill_r;
  logic [FILL_W-1:0]          rd_cnt_r;
  logic [PW-1:0]              pos_r;
  logic                       rd_vld_r;
  logic [NUM_CHANNELS-1:0]    meta_vld_r;
  logic signed [SAMPLE_W-1:0] mx_r;
  logic signed [SAMPLE_W-1:0] mn_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic                       div_done;
  logic [SAMPLE_W-1:0]        div_q;
  logic                       walk_end;
  logic                       out_valid_r;

  always_comb begin
    len_eff = window_len_r;
    if (window_len_r == '0) begin
      len_eff = FILL_W'(1);
    end else if (window_len_r > CAP_LEN) begin
      len_eff = CAP_LEN;
    end
  end

  assign walk_end = (rd_cnt_r == fill_r) && !rd_vld_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_META;
      ST_META: state_nxt = ST_WALK;
      ST_WALK: if (walk_end) state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_r)
      ST_IDLE: ctrl.in_ready = 1'b1;
      ST_META: begin
        ctrl.meta_we = 1'b1;
        ctrl.hist_we = 1'b1;
      end
      ST_WALK: begin
        ctrl.rd_issue  = (rd_cnt_r != fill_r);
        ctrl.div_start = walk_end;
      end
      ST_DIV:  ;
      ST_DONE: ctrl.out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = ctrl.in_ready;

  // Ring state RAM: {write position, fill}
  logic [CH_W-1:0]   meta_addr;
  logic [META_W-1:0] meta_wdata;
  logic [META_W-1:0] meta_rdata;
  logic [PW-1:0]     wp_raw;
  logic [PW-1:0]     wp_cur;
  logic [PW-1:0]     wp_new;
  logic [FILL_W-1:0] fill_old;
  logic [FILL_W:0]   fill_inc;
  logic [FILL_W-1:0] fill_new;
  logic              meta_ok;

  assign meta_addr = (state_r == ST_IDLE) ? ch_mod_tab[in_channel] : ch_r;
  assign meta_ok   = meta_vld_r[ch_r];

  always_comb begin
    wp_raw   = meta_ok ? meta_rdata[META_W-1:FILL_W] : '0;
    fill_old = meta_ok ? meta_rdata[FILL_W-1:0] : '0;
    wp_cur   = (wp_raw > LAST_POS) ? '0 : wp_raw;
    wp_new   = (wp_cur == LAST_POS) ? '0 : wp_cur + 1'b1;
    fill_inc = {1'b0, fill_old} + 1'b1;
    fill_new = (fill_inc > {1'b0, len_r}) ? len_r : fill_inc[FILL_W-1:0];
  end

  assign meta_wdata = {wp_new, fill_new};

  wmm_ram #(
    .WIDTH (META_W),
    .DEPTH (2 ** CH_W)
  ) u_meta_ram (
    .clk   (clk),
    .we    (ctrl.meta_we),
    .addr  (meta_addr),
    .wdata (meta_wdata),
    .rdata (meta_rdata)
  );

  // History RAM
  logic [PW-1:0]       pos_prev;
  logic [HA_W-1:0]     hist_addr;
  logic [SAMPLE_W-1:0] hist_rdata;
  logic signed [SAMPLE_W-1:0] hv;

  assign pos_prev  = (pos_r == '0) ? LAST_POS : pos_r - 1'b1;
  assign hist_addr = (state_r == ST_META) ? {ch_r, wp_cur} : {ch_r, pos_prev};
  assign hv        = $signed(hist_rdata);

  wmm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (2 ** HA_W)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ctrl.hist_we),
    .addr  (hist_addr),
    .wdata (sample_r),
    .rdata (hist_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_vld_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      if (ctrl.meta_we) begin
        meta_vld_r[ch_r] <= 1'b1;
      end
      rd_vld_r <= ctrl.rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ctrl.in_ready) begin
      ch_r     <= ch_mod_tab[in_channel];
      sample_r <= in_sample;
      len_r    <= len_eff;
    end
    if (ctrl.meta_we) begin
      pos_r    <= wp_new;
      fill_r   <= fill_new;
      rd_cnt_r <= '0;
      mx_r     <= {1'b1, {(SAMPLE_W - 1){1'b0}}};
      mn_r     <= {1'b0, {(SAMPLE_W - 1){1'b1}}};
      sum_r    <= '0;
    end else begin
      if (ctrl.rd_issue) begin
        pos_r    <= pos_prev;
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
      if (rd_vld_r) begin
        if (hv > mx_r) mx_r <= hv;
        if (hv < mn_r) mn_r <= hv;
        sum_r <= sum_r + SUM_W'(hv);
      end
    end
  end

  wmm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.div_start),
    .dividend (sum_r),
    .divisor  (fill_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_max_value  <= mx_r;
      out_min_value  <= mn_r;
      out_mean_value <= $signed(div_q);
      out_fill_count <= fill_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- sim/tb_windowed_min_max_mean_top.sv -----
// Testbench for windowed_min_max_mean_top: directed table, then random phases checked by a predictor.
`timescale 1ns / 1ps

module tb_windowed_min_max_mean_top;
  import wmm_pkg::*;

  localparam int CHANNELS = 16;
  localparam int DEPTH    = 64;
  localparam int PHASES   = 14;
  localparam int PHASE_BEATS = 120;
  localparam logic [ADDR_W-1:0] LEN_ADDR = ADDR_W'(4 * int'(REG_WINDOW_LEN));

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] max_v;
    logic signed [SAMPLE_W-1:0] min_v;
    logic signed [SAMPLE_W-1:0] mean_v;
    logic [FILL_W-1:0]          fill;
  } stats_t;

  typedef enum logic {ROW_BEAT, ROW_LEN} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [3:0]  ch;
    logic [31:0] val;
    logic        typed;
    stats_t      want;
  } row_t;

  localparam row_t DIRECTED [0:19] = '{
    '{ROW_BEAT, 4'd0,  32'h7FFFFFFF, 1'b1,
      '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 7'd1}},
    '{ROW_BEAT, 4'd15, 32'h80000000, 1'b1,
      '{32'h80000000, 32'h80000000, 32'h80000000, 7'd1}},
    '{ROW_BEAT, 4'd0,  32'h80000000, 1'b1,
      '{32'h7FFFFFFF, 32'h80000000, 32'h00000000, 7'd2}},
    '{ROW_BEAT, 4'd15, 32'hFFFFFFFF, 1'b0, '0},
    '{ROW_BEAT, 4'd7,  32'h00000000, 1'b1, '{32'h0, 32'h0, 32'h0, 7'd1}},
    '{ROW_BEAT, 4'd7,  32'hFFFFFFFD, 1'b0, '0},
    '{ROW_BEAT, 4'd7,  32'h55555555, 1'b0, '0},
    '{ROW_BEAT, 4'd7,  32'hAAAAAAAA, 1'b0, '0},
    '{ROW_LEN,  4'd0,  32'd1,        1'b0, '0},
    '{ROW_BEAT, 4'd7,  32'd5,        1'b1, '{32'd5, 32'd5, 32'd5, 7'd1}},
    '{ROW_LEN,  4'd0,  32'd0,        1'b0, '0},
    '{ROW_BEAT, 4'd0,  32'hFFFFFFF9, 1'b1,
      '{32'hFFFFFFF9, 32'hFFFFFFF9, 32'hFFFFFFF9, 7'd1}},
    '{ROW_LEN,  4'd0,  32'd127,      1'b0, '0},
    '{ROW_BEAT, 4'd0,  32'd100,      1'b0, '0},
    '{ROW_BEAT, 4'd0,  32'hFFFFFF9C, 1'b0, '0},
    '{ROW_LEN,  4'd0,  32'd3,        1'b0, '0},
    '{ROW_BEAT, 4'd15, 32'd1,        1'b0, '0},
    '{ROW_BEAT, 4'd15, 32'd2,        1'b0, '0},
    '{ROW_BEAT, 4'd15, 32'd3,        1'b0, '0},
    '{ROW_BEAT, 4'd15, 32'd4,        1'b0, '0}
  };

  localparam logic [FILL_W-1:0] PHASE_LEN [0:PHASES-1] = '{
    7'd64, 7'd1, 7'd127, 7'd0, 7'd17, 7'd64, 7'd3,
    7'd100, 7'd64, 7'd2, 7'd45, 7'd127, 7'd8, 7'd64
  };

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready;
  logic [3:0] in_channel;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic out_valid, out_ready;
  logic signed [SAMPLE_W-1:0] out_max_value, out_min_value, out_mean_value;
  logic [FILL_W-1:0] out_fill_count;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata, cfg_prdata;

  logic signed [SAMPLE_W-1:0] ring [CHANNELS][DEPTH];
  int unsigned wr_pos [CHANNELS] = '{default: 0};
  int unsigned fill_cnt [CHANNELS] = '{default: 0};
  logic [FILL_W-1:0] cfg_len = WINDOW_LEN_RST;

  stats_t pending_stats [$];
  int err_count = 0;
  int gap_max = 16;
  int stall_max = 16;

  windowed_min_max_mean_top uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t MISMATCH %s: got %h want %h", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic stats_t window_stats(input logic [3:0] ch,
                                          input logic signed [SAMPLE_W-1:0] smp);
    int unsigned len, fill, pos;
    longint hi, lo, total, v;
    stats_t r;
    len = (cfg_len == 0) ? 1 : ((cfg_len > DEPTH) ? DEPTH : cfg_len);
    ring[ch][wr_pos[ch]] = smp;
    wr_pos[ch] = (wr_pos[ch] + 1) % DEPTH;
    fill = fill_cnt[ch] + 1;
    if (fill > len) fill = len;
    fill_cnt[ch] = fill;
    pos = wr_pos[ch];
    hi = longint'(ring[ch][(pos + DEPTH - 1) % DEPTH]);
    lo = hi;
    total = 0;
    for (int k = 0; k < fill; k++) begin
      pos = (pos == 0) ? DEPTH - 1 : pos - 1;
      v = longint'(ring[ch][pos]);
      if (v > hi) hi = v;
      if (v < lo) lo = v;
      total += v;
    end
    r.max_v  = hi[SAMPLE_W-1:0];
    r.min_v  = lo[SAMPLE_W-1:0];
    v = total / longint'(fill);
    r.mean_v = v[SAMPLE_W-1:0];
    r.fill   = FILL_W'(fill);
    return r;
  endfunction

  function automatic logic [31:0] pick_sample();
    logic [31:0] s;
    case ($urandom_range(9, 0))
      0: s = 32'h7FFFFFFF;
      1: s = 32'h80000000;
      2: s = 32'h00000000;
      3: s = 32'hFFFFFFFF;
      4, 5: s = 32'($urandom_range(200, 0)) - 32'd100;
      default: s = $urandom;
    endcase
    return s;
  endfunction

  // entered and left just after a falling edge
  task automatic send_beat(input logic [3:0] ch, input logic [31:0] smp,
                           input logic typed, input stats_t typed_want);
    int gap;
    stats_t want;
    gap = $urandom_range(gap_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_channel <= ch;
    in_sample  <= smp;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ready);
    want = window_stats(ch, smp);
    pending_stats.insert(pending_stats.size(), typed ? typed_want : want);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic check_window_len(input logic [FILL_W-1:0] want);
    logic [DATA_W-1:0] got;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= LEN_ADDR;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== DATA_W'(want)) report_mismatch("window_len readback", got, DATA_W'(want));
  endtask

  task automatic program_window_len(input logic [FILL_W-1:0] len);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= LEN_ADDR;
    cfg_pwdata  <= DATA_W'(len);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_len = len;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    check_window_len(len);
  endtask

  always @(posedge clk) begin : result_check
    stats_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_stats.size() == 0) begin
        report_mismatch("result beat with nothing pending", out_max_value, '0);
      end else begin
        want = pending_stats.pop_front();
        if (out_max_value !== want.max_v)
          report_mismatch("max_value", out_max_value, want.max_v);
        if (out_min_value !== want.min_v)
          report_mismatch("min_value", out_min_value, want.min_v);
        if (out_mean_value !== want.mean_v)
          report_mismatch("mean_value", out_mean_value, want.mean_v);
        if (out_fill_count !== want.fill)
          report_mismatch("fill_count", 32'(out_fill_count), 32'(want.fill));
      end
    end
  end

  initial begin : result_sink
    int gap;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      gap = $urandom_range(stall_max, 0);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_valid));
      @(negedge clk);
    end
  end

  initial begin
    #12_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int base, span;
    logic [FILL_W-1:0] len;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_channel  = '0;
    in_sample   = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    check_window_len(WINDOW_LEN_RST);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_LEN) begin
        settle();
        program_window_len(DIRECTED[i].val[FILL_W-1:0]);
      end else begin
        send_beat(DIRECTED[i].ch, DIRECTED[i].val, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      len = (p % 4 == 3) ? FILL_W'($urandom_range(127, 0)) : PHASE_LEN[p];
      program_window_len(len);
      gap_max   = (p % 5 == 2) ? 0 : 16;
      stall_max = (p % 5 == 2 || p % 5 == 3) ? 0 : 16;
      case (p % 3)
        0: span = 1;
        1: span = 3;
        default: span = CHANNELS;
      endcase
      base = $urandom_range(CHANNELS - 1, 0);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if ($urandom_range(60, 0) == 0) settle();
        send_beat(4'(base + $urandom_range(span - 1, 0)), pick_sample(), 1'b0, '0);
      end
    end

    settle();
    repeat (120) @(negedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
